// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the SD wide bus data CRC unit.
// The caller supplies clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sdcrc_pkg.sv
// Package for the SD wide bus data CRC unit: payload types and the CRC update.
// No dependencies; used by sd_wide_bus_data_crc16_unit, sd_crc_checker and testbench.
package sdcrc_pkg;

    localparam int WORD_W = 16;
    localparam int ACC_W = 4 * WORD_W;
    localparam int RES_CNT_W = 3;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_CRC = 1'b1;
    localparam logic MODE_GEN = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // Spread polynomial: x^48 + x^20 + 1 applied to the 16-bit feedback word.
    localparam int POLY_SHIFT_MID = 20;
    localparam int POLY_SHIFT_TOP = 48;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] word;
        logic              last_data;
    } sdcrc_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] crc_word;
        logic              status;
        logic              last_of_run;
    } sdcrc_out_t;

    // One 16-bit word into the four interleaved CRC-16 registers. The three
    // shifted copies of the feedback word never overlap.
    function automatic logic [ACC_W-1:0] crc_update(input logic [ACC_W-1:0] acc,
                                                    input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] x;
        logic [ACC_W-1:0]  xe;
        x  = acc[ACC_W-1 -: WORD_W] ^ w;
        xe = {{(ACC_W-WORD_W){1'b0}}, x};
        return (acc << WORD_W) ^ xe ^ (xe << POLY_SHIFT_MID) ^ (xe << POLY_SHIFT_TOP);
    endfunction

endpackage

// File: rtl/core/sd_wide_bus_data_crc16_unit.sv
// Top level of the SD wide bus data CRC unit: input register, CRC state and
// result buffer. Depends on sdcrc_pkg and assert_macros.svh.
//
// Usage: data words of a block enter on the in_valid/in_ready channel, one
// 16-bit word per transaction, the last one flagged by last_data. With mode 0
// the last data word yields four results carrying the CRC words, most
// significant first; with mode 1 four received CRC words (func set) must
// follow, and after the fourth one status result reports a mismatch. Results
// leave on the out_valid/out_ready channel; last_of_run flags the final
// result of a transaction. The mode register is written through cfg_we and
// cfg_wdata while the unit is idle; it is sampled when a block ends.
// A transaction is held in the input register until it can be processed, and
// its results are registered in the result buffer before the receiver takes
// them. Throughput is one transaction per cycle while the result buffer is
// empty or its last result is being taken. A generate-mode block end fills the
// buffer with four CRC words, and the next transaction waits in the input
// register until the last word leaves; it moves on in the cycle that word leaves.
// When the receiver stalls, the result buffer holds its contents and the
// input register still takes one more transaction before in_ready drops.
// Reset clears the CRC state and the mode register and empties both stages.

`include "assert_macros.svh"

module sd_wide_bus_data_crc16_unit
    import sdcrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  sdcrc_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output sdcrc_out_t out_data
);

    logic                 mode_reg;
    logic                 in_vld_reg;
    sdcrc_in_t            in_reg;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 await_reg, await_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 mis_reg, mis_next;
    logic [ACC_W-1:0]     buf_reg, buf_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 stat_reg, stat_next;
    logic                 statval_reg, statval_next;

    logic                 can_load, process, pop;
    logic                 emit_gen, emit_stat, mis_hit;
    logic [ACC_W-1:0]     acc_upd;
    logic [WORD_W-1:0]    slice;

    assign can_load  = (cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && out_ready);
    assign process   = in_vld_reg && can_load;
    assign in_ready  = !in_vld_reg || process;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;

    assign acc_upd = crc_update(acc_reg, in_reg.word);
    assign slice   = acc_reg[ACC_W - 1 - WORD_W * idx_reg -: WORD_W];
    assign mis_hit = mis_reg || (in_reg.word != slice);

    always_comb
    begin
        acc_next     = acc_reg;
        await_next   = await_reg;
        idx_next     = idx_reg;
        mis_next     = mis_reg;
        emit_gen     = 1'b0;
        emit_stat    = 1'b0;
        statval_next = statval_reg;
        if (process)
        begin
            if (await_reg)
            begin
                if (in_reg.func == FUNC_CRC)
                begin
                    if (idx_reg != 2'd3)
                    begin
                        idx_next = idx_reg + 2'd1;
                        mis_next = mis_hit;
                    end
                    else
                    begin
                        emit_stat    = 1'b1;
                        statval_next = mis_hit;
                        acc_next     = '0;
                        await_next   = 1'b0;
                        idx_next     = '0;
                        mis_next     = 1'b0;
                    end
                end
            end
            else if (in_reg.func == FUNC_DATA)
            begin
                acc_next = acc_upd;
                if (in_reg.last_data)
                begin
                    if (mode_reg == MODE_CHECK)
                    begin
                        await_next = 1'b1;
                        idx_next   = '0;
                        mis_next   = 1'b0;
                    end
                    else
                    begin
                        emit_gen = 1'b1;
                        acc_next = '0;
                    end
                end
            end
        end
    end

    // Result buffer: four CRC words shift out from the top, or one status result.
    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        stat_next = stat_reg;
        if (emit_gen)
        begin
            buf_next  = acc_upd;
            cnt_next  = RES_CNT_W'(4);
            stat_next = 1'b0;
        end
        else if (emit_stat)
        begin
            cnt_next  = RES_CNT_W'(1);
            stat_next = 1'b1;
        end
        else if (pop)
        begin
            buf_next = buf_reg << WORD_W;
            cnt_next = cnt_reg - RES_CNT_W'(1);
        end
    end

    assign out_data.crc_word    = stat_reg ? '0 : buf_reg[ACC_W-1 -: WORD_W];
    assign out_data.status      = stat_reg && statval_reg;
    assign out_data.last_of_run = (cnt_reg == RES_CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_GEN;
            in_vld_reg  <= 1'b0;
            acc_reg     <= '0;
            await_reg   <= 1'b0;
            idx_reg     <= '0;
            mis_reg     <= 1'b0;
            cnt_reg     <= '0;
            stat_reg    <= 1'b0;
            statval_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            acc_reg     <= acc_next;
            await_reg   <= await_next;
            idx_reg     <= idx_next;
            mis_reg     <= mis_next;
            cnt_reg     <= cnt_next;
            stat_reg    <= stat_next;
            statval_reg <= statval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
        buf_reg <= buf_next;
    end

    `ASSERT_SAME(a_cnt_range, 1'b1, cnt_reg <= RES_CNT_W'(4), "result count above four")
    `ASSERT_SAME(a_idle_check, !await_reg, (idx_reg == 2'd0) && !mis_reg,
                 "check counters active outside a check phase")
    `ASSERT_SAME(a_status_form, out_valid && stat_reg,
                 (out_data.crc_word == '0) && out_data.last_of_run,
                 "status result is not a single zero-word result")
    `ASSERT_NEXT(a_gen_load, emit_gen, cnt_reg == RES_CNT_W'(4) && acc_reg == '0,
                 "block end did not load four CRC words")

endmodule

// File: tb/sd_crc_checker.sv
// Checker for the SD wide bus data CRC unit: watches the input, result and mode
// write ports, predicts the results of every transaction and compares them.
// Depends on sdcrc_pkg.
module sd_crc_checker
    import sdcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  sdcrc_in_t         in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  sdcrc_out_t        out_data,
    output int                fail_count,
    output int                results_due,
    output logic [ACC_W-1:0]  block_crc
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACC_W-1:0] SPREAD_POLY = 64'h0001_0000_0010_0001;

    sdcrc_out_t         due_q[$];
    logic [ACC_W-1:0]   crc_acc;
    logic               await_crc;
    logic [1:0]         rx_index;
    logic               rx_bad;
    logic               mode_reg;

    assign block_crc = crc_acc;

    // The feedback word times the spread polynomial: its three shifted copies
    // land on disjoint bits, so the product is a plain XOR of them.
    function automatic logic [ACC_W-1:0] crc_advance(input logic [ACC_W-1:0] acc,
                                                     input logic [WORD_W-1:0] w);
        logic [ACC_W-1:0] fb;
        fb = {{(ACC_W-WORD_W){1'b0}}, acc[ACC_W-1 -: WORD_W] ^ w};
        return (acc << WORD_W) ^ (fb * SPREAD_POLY);
    endfunction

    function automatic logic [WORD_W-1:0] crc_lane(input logic [ACC_W-1:0] acc,
                                                   input int idx);
        return acc[ACC_W-1-WORD_W*idx -: WORD_W];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_result(input sdcrc_out_t got);
        sdcrc_out_t want;
        if (due_q.size() == 0)
        begin
            report_mismatch("result with nothing outstanding", int'(got), 0);
            return;
        end
        want = due_q.pop_front();
        if (got.crc_word != want.crc_word)
            report_mismatch("crc_word", int'(got.crc_word), int'(want.crc_word));
        if (got.status != want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
        if (got.last_of_run != want.last_of_run)
            report_mismatch("last_of_run", int'(got.last_of_run),
                            int'(want.last_of_run));
    endtask

    task automatic predict(input sdcrc_in_t it);
        sdcrc_out_t r;
        if (await_crc)
        begin
            // Data words are dropped while the received CRC words are pending.
            if (it.func == FUNC_CRC)
            begin
                if (it.word != crc_lane(crc_acc, rx_index))
                    rx_bad = 1'b1;
                if (rx_index != 2'd3)
                    rx_index = rx_index + 2'd1;
                else
                begin
                    r.crc_word = '0;
                    r.status = rx_bad;
                    r.last_of_run = 1'b1;
                    due_q.push_back(r);
                    crc_acc = '0;
                    await_crc = 1'b0;
                    rx_index = '0;
                    rx_bad = 1'b0;
                end
            end
        end
        else if (it.func == FUNC_DATA)
        begin
            crc_acc = crc_advance(crc_acc, it.word);
            if (it.last_data)
            begin
                if (mode_reg == MODE_CHECK)
                begin
                    await_crc = 1'b1;
                    rx_index = '0;
                    rx_bad = 1'b0;
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        r.crc_word = crc_lane(crc_acc, k);
                        r.status = 1'b0;
                        r.last_of_run = (k == 3);
                        due_q.push_back(r);
                    end
                    crc_acc = '0;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_q.delete();
            crc_acc = '0;
            await_crc = 1'b0;
            rx_index = '0;
            rx_bad = 1'b0;
            mode_reg = MODE_GEN;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                predict(in_data);
            if (cfg_we)
                mode_reg = cfg_wdata;
        end
        results_due = due_q.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the testbench for sd_wide_bus_data_crc16_unit: clock, reset, stimulus
// and verdict. Depends on sdcrc_pkg, the unit itself and sd_crc_checker.
module testbench;
    import sdcrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int FINAL_WAIT_LIMIT = 5000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_wdata = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    sdcrc_in_t        in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    sdcrc_out_t       out_data;
    int               fail_count;
    int               results_due;
    logic [ACC_W-1:0] block_crc;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               cycle_count = 0;
    logic             cur_mode = MODE_GEN;

    sd_wide_bus_data_crc16_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    sd_crc_checker crc_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .results_due (results_due),
        .block_crc   (block_crc)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return '0;
        else if (sel == 2)
            return '1;
        else if (sel < 5)
            return WORD_W'(1) << $urandom_range(0, WORD_W-1);
        return WORD_W'($urandom);
    endfunction

    // Presents one transaction and returns at the falling edge after it was taken.
    task automatic send_item(input logic func, input logic [WORD_W-1:0] w,
                             input logic last);
        sdcrc_in_t it;
        it.func = func;
        it.word = w;
        it.last_data = last;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Sends the four received CRC words of the block just closed, optionally
    // with one word corrupted and stray data words in between.
    task automatic send_crc_words(input int bad_idx, input logic [WORD_W-1:0] bad_mask,
                                  input int flag_idx, input bit noisy);
        logic [ACC_W-1:0]  sig;
        logic [WORD_W-1:0] w;
        sig = block_crc;
        for (int k = 0; k < 4; k++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(FUNC_DATA, pick_word(), 1'($urandom_range(0, 1)));
            w = sig[ACC_W-1-WORD_W*k -: WORD_W];
            if (k == bad_idx)
                w = w ^ bad_mask;
            send_item(FUNC_CRC, w, k == flag_idx);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_wdata <= m;
        cfg_we <= 1'b1;
        cur_mode = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int phase);
        int target;
        int len;
        int sent;
        sent = 0;
        for (int seg = 0; seg < 4; seg++)
        begin
            settle();
            write_mode(((seg + phase) % 2 == 1) ? MODE_CHECK : MODE_GEN);
            target = sent + 18;
            while (sent < target)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_item(1'($urandom_range(0, 1)), pick_word(),
                              1'($urandom_range(0, 1)));
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
                                                  : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_item(FUNC_DATA, pick_word(), i == len - 1);
                sent += len;
                if (cur_mode == MODE_CHECK)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_crc_words($urandom_range(0, 3),
                                       WORD_W'(1) << $urandom_range(0, WORD_W-1),
                                       int'($urandom_range(0, 4)) - 1, 1'b1);
                    else
                        send_crc_words(-1, '0, int'($urandom_range(0, 4)) - 1, 1'b1);
                    sent += 4;
                end
            end
        end
    endtask

    initial
    begin
        int waited;
        send_idle_pct = 34;
        recv_idle_pct = 50;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Generate mode: single-word blocks at the extremes, a longer block,
        // and a stray CRC word that must be dropped.
        write_mode(MODE_GEN);
        send_item(FUNC_DATA, 16'h0000, 1'b1);
        send_item(FUNC_DATA, 16'hFFFF, 1'b1);
        send_item(FUNC_DATA, 16'h8000, 1'b0);
        send_item(FUNC_DATA, 16'h0001, 1'b0);
        send_item(FUNC_DATA, 16'hA5A5, 1'b1);
        send_item(FUNC_CRC, 16'h1234, 1'b1);

        // Check mode: a good block with a data word while CRC words are pending
        // and last_data on a CRC word, then a block with one corrupted word.
        settle();
        write_mode(MODE_CHECK);
        send_item(FUNC_DATA, 16'h1234, 1'b0);
        send_item(FUNC_DATA, 16'hFFFF, 1'b1);
        send_item(FUNC_DATA, 16'h5A5A, 1'b1);
        send_crc_words(-1, '0, 1, 1'b0);
        send_item(FUNC_DATA, 16'h0000, 1'b1);
        send_crc_words(2, 16'h0100, -1, 1'b0);

        // The mode is taken at the end of a block, not when it is written.
        send_item(FUNC_DATA, 16'h5555, 1'b0);
        settle();
        write_mode(MODE_GEN);
        send_item(FUNC_DATA, 16'hAAAA, 1'b1);
        settle();
        write_mode(MODE_CHECK);
        send_item(FUNC_DATA, 16'h7FFF, 1'b1);
        settle();
        write_mode(MODE_GEN);
        send_crc_words(-1, '0, 3, 1'b0);

        run_random(0);
        send_idle_pct = 50;
        recv_idle_pct = 34;
        run_random(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(2);

        in_valid <= 1'b0;
        waited = 0;
        while (results_due != 0 && waited < FINAL_WAIT_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sdcrc_pkg.sv
rtl/core/sd_wide_bus_data_crc16_unit.sv
tb/sd_crc_checker.sv
tb/testbench.sv
